// ===== hw/rtl/ttss_pkg.sv =====
`default_nettype none

package ttss_pkg;

	// default table size and command queue depth
	localparam int SLOT_COUNT_DEF = 16;
	localparam int QUEUE_DEPTH    = 2;

	// opcode codes
	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_ADDED = 2'd0;
	localparam logic [1:0] KIND_FULL  = 2'd1;
	localparam logic [1:0] KIND_FIRED = 2'd2;

	// input transaction
	typedef struct packed {
		logic        opcode;
		logic [31:0] now_ms;
		logic [31:0] start_delay;
		logic [31:0] repeat_period;
		logic        is_repeating;
	} in_item_t;

	// output transaction
	typedef struct packed {
		logic [1:0] result_kind;
		logic [3:0] slot_index;
		logic       last_of_run;
	} out_item_t;

	// classified command passed from front to back
	typedef struct packed {
		logic        is_tick;
		logic [31:0] time_ms;
		logic [31:0] period;
		logic        repeating;
	} cmd_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// one slot of the task table
	typedef struct packed {
		logic [31:0] due;
		logic [31:0] period;
		logic        repeating;
	} slot_entry_t;

	// back end sequencer states
	typedef enum logic [1:0] {
		B_IDLE,
		B_READ,
		B_EVAL,
		B_FLUSH
	} back_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ttss_front.sv =====
`default_nettype none

module ttss_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire ttss_pkg::in_item_t req,
	input  wire ttss_pkg::q_stat_t q_stat,
	output logic                   push,
	output ttss_pkg::cmd_t         cmd
);

	ttss_pkg::cmd_t cmd_s1;
	logic           valid_s1;
	logic           take;

	// hand the held command to the queue when it has room
	assign push      = valid_s1 && !q_stat.full;
	assign req_ready = !valid_s1 || push;
	assign take      = req_valid && req_ready;
	assign cmd       = cmd_s1;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// classify the transaction and precompute the first due time
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.is_tick   <= (req.opcode == ttss_pkg::OP_TICK);
			cmd_s1.time_ms   <= (req.opcode == ttss_pkg::OP_TICK) ? req.now_ms
				: req.now_ms + req.start_delay;
			cmd_s1.period    <= req.repeat_period;
			cmd_s1.repeating <= req.is_repeating;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ttss_queue.sv =====
`default_nettype none

module ttss_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire ttss_pkg::cmd_t push_cmd,
	input  wire logic           pop,
	output ttss_pkg::cmd_t      head,
	output ttss_pkg::q_stat_t   stat
);

	localparam int DEPTH = ttss_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	ttss_pkg::cmd_t entry_q [DEPTH];
	logic [PW-1:0]  wptr_q;
	logic [PW-1:0]  rptr_q;
	logic [CW-1:0]  count_q;

	assign head       = entry_q[rptr_q];
	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ttss_back.sv =====
`default_nettype none

module ttss_back #(
	parameter int SLOT_COUNT = ttss_pkg::SLOT_COUNT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ttss_pkg::cmd_t     cmd,
	input  wire ttss_pkg::q_stat_t  q_stat,
	output logic                    pop,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output ttss_pkg::out_item_t     rsp
);

	localparam int IDXW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNTW = $clog2(SLOT_COUNT + 1);
	localparam int EXTW = IDXW + 4;

	ttss_pkg::back_state_t state_q, state_d;

	ttss_pkg::slot_entry_t slot_mem [SLOT_COUNT];
	ttss_pkg::slot_entry_t rd_q;

	logic [SLOT_COUNT-1:0] active_q;
	logic [CNTW-1:0]       slots_used_q;
	logic [IDXW-1:0]       idx_q;
	logic [31:0]           now_q;
	logic [IDXW-1:0]       pend_q;
	logic                  pend_valid_q;
	logic                  rsp_valid_q;
	ttss_pkg::out_item_t   rsp_q;

	logic                  cmd_valid;
	logic                  out_free;
	logic                  table_full;
	logic [IDXW-1:0]       add_slot;
	logic                  fire;
	logic                  advance;
	logic                  idx_last;
	logic [EXTW-1:0]       add_ext;
	logic [EXTW-1:0]       pend_ext;

	logic                  tick_start;
	logic                  add_write;
	logic                  rsp_load;
	ttss_pkg::out_item_t   rsp_d;
	logic                  mem_we;
	logic [IDXW-1:0]       mem_wa;
	ttss_pkg::slot_entry_t mem_wd;
	logic                  act_clr;
	logic                  fire_take;

	assign cmd_valid  = !q_stat.empty;
	assign out_free   = !rsp_valid_q || rsp_ready;
	assign table_full = (slots_used_q >= CNTW'(SLOT_COUNT));
	assign add_slot   = IDXW'(slots_used_q);
	assign fire       = active_q[idx_q] && (now_q >= rd_q.due);
	assign advance    = !fire || !pend_valid_q || out_free;
	assign idx_last   = ((CNTW'(idx_q) + CNTW'(1)) == slots_used_q);
	assign add_ext    = EXTW'(add_slot);
	assign pend_ext   = EXTW'(pend_q);

	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ttss_pkg::B_IDLE: begin
				if (cmd_valid && cmd.is_tick && (slots_used_q != '0)) begin
					state_d = ttss_pkg::B_READ;
				end
			end
			ttss_pkg::B_READ: begin
				state_d = ttss_pkg::B_EVAL;
			end
			ttss_pkg::B_EVAL: begin
				if (advance) begin
					state_d = idx_last ? ttss_pkg::B_FLUSH : ttss_pkg::B_READ;
				end
			end
			ttss_pkg::B_FLUSH: begin
				if (!pend_valid_q || out_free) begin
					state_d = ttss_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = ttss_pkg::B_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		pop        = 1'b0;
		tick_start = 1'b0;
		add_write  = 1'b0;
		rsp_load   = 1'b0;
		rsp_d      = '0;
		mem_we     = 1'b0;
		mem_wa     = idx_q;
		mem_wd     = rd_q;
		act_clr    = 1'b0;
		fire_take  = 1'b0;
		case (state_q)
			ttss_pkg::B_IDLE: begin
				if (cmd_valid && cmd.is_tick) begin
					pop        = 1'b1;
					tick_start = 1'b1;
				end else if (cmd_valid && out_free) begin
					pop               = 1'b1;
					rsp_load          = 1'b1;
					rsp_d.last_of_run = 1'b1;
					if (table_full) begin
						rsp_d.result_kind = ttss_pkg::KIND_FULL;
						rsp_d.slot_index  = 4'd0;
					end else begin
						rsp_d.result_kind = ttss_pkg::KIND_ADDED;
						rsp_d.slot_index  = add_ext[3:0];
						add_write         = 1'b1;
						mem_we            = 1'b1;
						mem_wa            = add_slot;
						mem_wd.due        = cmd.time_ms;
						mem_wd.period     = cmd.period;
						mem_wd.repeating  = cmd.repeating;
					end
				end
			end
			ttss_pkg::B_EVAL: begin
				if (fire && advance) begin
					fire_take = 1'b1;
					// the held hit is not the last one, release it now
					if (pend_valid_q) begin
						rsp_load          = 1'b1;
						rsp_d.result_kind = ttss_pkg::KIND_FIRED;
						rsp_d.slot_index  = pend_ext[3:0];
						rsp_d.last_of_run = 1'b0;
					end
					if (rd_q.repeating && (rd_q.period != '0)) begin
						mem_we     = 1'b1;
						mem_wd.due = rd_q.due + rd_q.period;
					end else begin
						act_clr = 1'b1;
					end
				end
			end
			ttss_pkg::B_FLUSH: begin
				if (pend_valid_q && out_free) begin
					rsp_load          = 1'b1;
					rsp_d.result_kind = ttss_pkg::KIND_FIRED;
					rsp_d.slot_index  = pend_ext[3:0];
					rsp_d.last_of_run = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ttss_pkg::B_IDLE;
			slots_used_q <= '0;
			active_q     <= '0;
			pend_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
			idx_q        <= '0;
		end else begin
			state_q <= state_d;
			if (add_write) begin
				slots_used_q       <= slots_used_q + CNTW'(1);
				active_q[add_slot] <= 1'b1;
			end
			if (act_clr) begin
				active_q[idx_q] <= 1'b0;
			end
			if (tick_start) begin
				idx_q        <= '0;
				pend_valid_q <= 1'b0;
			end else if (state_q == ttss_pkg::B_EVAL && advance) begin
				idx_q <= IDXW'(CNTW'(idx_q) + CNTW'(1));
				if (fire_take) begin
					pend_valid_q <= 1'b1;
				end
			end else if (state_q == ttss_pkg::B_FLUSH && out_free) begin
				pend_valid_q <= 1'b0;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (tick_start) begin
			now_q <= cmd.time_ms;
		end
		if (fire_take) begin
			pend_q <= idx_q;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	// slot table, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_wa] <= mem_wd;
		end
		rd_q <= slot_mem[idx_q];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/timed_task_slot_scheduler_core.sv =====
`default_nettype none

// Time-triggered task slot scheduler. An add transaction books the next unused slot with
// due time now_ms + start_delay and answers with its slot number, or with a table-full
// result; the back end handles it once the output register is free. A tick
// transaction scans the filled slots from slot 0 up and answers with one fired result per
// due slot, the final one flagged by last_of_run; a tick with nothing due answers nothing.
// Each filled slot is read, then compared and written back, through the slot table's
// single registered read port, and the scan ends with a flush of the held hit. The
// front end buffers incoming transactions in a short command queue, so input is taken
// while a scan is running.
module timed_task_slot_scheduler_core #(
	parameter int SLOT_COUNT = ttss_pkg::SLOT_COUNT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire ttss_pkg::in_item_t req,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output ttss_pkg::out_item_t     rsp
);

	ttss_pkg::q_stat_t q_stat;
	ttss_pkg::cmd_t    push_cmd;
	ttss_pkg::cmd_t    head_cmd;
	logic              q_push;
	logic              q_pop;

	// accept and classify
	ttss_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.q_stat    (q_stat),
		.push      (q_push),
		.cmd       (push_cmd)
	);

	// command queue
	ttss_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.head     (head_cmd),
		.stat     (q_stat)
	);

	// slot table and scan
	ttss_back #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head_cmd),
		.q_stat    (q_stat),
		.pop       (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("command queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("command queue read while empty");

	a_add_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.result_kind == ttss_pkg::KIND_FIRED || rsp.last_of_run))
		else $error("add answer without last_of_run");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.result_kind == ttss_pkg::KIND_ADDED
			|| rsp.result_kind == ttss_pkg::KIND_FULL
			|| rsp.result_kind == ttss_pkg::KIND_FIRED))
		else $error("illegal result kind");
`endif

endmodule

`default_nettype wire

// ===== sim/timed_task_slot_scheduler_core_tb.sv =====
`default_nettype none

module timed_task_slot_scheduler_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS       = ttss_pkg::SLOT_COUNT_DEF;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE      = 100;

	// one queued stimulus transaction, optionally held until all results are back
	typedef struct packed {
		logic               hold_for_drain;
		ttss_pkg::in_item_t item;
	} cmd_entry_t;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	ttss_pkg::in_item_t  req       = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	ttss_pkg::out_item_t rsp;

	// stimulus backlog and expected slot events
	cmd_entry_t          cmd_backlog[$];
	ttss_pkg::out_item_t slot_events_q[$];

	// shadow copy of the slot table
	logic [31:0] slot_due    [SLOTS];
	logic [31:0] slot_period [SLOTS];
	logic        slot_repeats[SLOTS];
	logic        slot_armed  [SLOTS];
	int          slots_taken;

	int                  send_gap;
	bit                  send_burst;
	int                  sink_stall;
	int                  hold_draw;
	bit                  sink_burst;
	ttss_pkg::out_item_t want;
	int                  mismatches;
	int                  quiet_cycles;

	timed_task_slot_scheduler_core #(
		.SLOT_COUNT(SLOTS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// book a slot or scan the table, queueing the slot events this transaction causes
	task automatic predict_slot_events(input ttss_pkg::in_item_t t);
		ttss_pkg::out_item_t run [SLOTS];
		ttss_pkg::out_item_t r;
		int                  n;
		r = '0;
		n = 0;
		if (t.opcode == ttss_pkg::OP_ADD) begin
			r.last_of_run = 1'b1;
			if (slots_taken >= SLOTS) begin
				r.result_kind = ttss_pkg::KIND_FULL;
			end else begin
				slot_due[slots_taken]     = t.now_ms + t.start_delay;
				slot_period[slots_taken]  = t.repeat_period;
				slot_repeats[slots_taken] = t.is_repeating;
				slot_armed[slots_taken]   = 1'b1;
				r.result_kind             = ttss_pkg::KIND_ADDED;
				r.slot_index              = slots_taken[3:0];
				slots_taken++;
			end
			slot_events_q.push_back(r);
		end else begin
			for (int i = 0; i < slots_taken; i++) begin
				if (slot_armed[i] && t.now_ms >= slot_due[i]) begin
					r.result_kind = ttss_pkg::KIND_FIRED;
					r.slot_index  = i[3:0];
					r.last_of_run = 1'b0;
					run[n]        = r;
					n++;
					// repeating with a zero period behaves as one-shot
					if (slot_repeats[i] && slot_period[i] != 32'd0)
						slot_due[i] = slot_due[i] + slot_period[i];
					else
						slot_armed[i] = 1'b0;
				end
			end
			if (n > 0)
				run[n-1].last_of_run = 1'b1;
			for (int k = 0; k < n; k++)
				slot_events_q.push_back(run[k]);
		end
	endtask

	function automatic void queue_cmd(input logic op, input logic [31:0] now,
		input logic [31:0] delay, input logic [31:0] per, input logic rep,
		input logic hold);
		cmd_entry_t e;
		e.hold_for_drain     = hold;
		e.item.opcode        = op;
		e.item.now_ms        = now;
		e.item.start_delay   = delay;
		e.item.repeat_period = per;
		e.item.is_repeating  = rep;
		cmd_backlog.push_back(e);
	endfunction

	// request driver, predicts on every accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
			send_gap  <= 0;
		end else begin
			if (req_valid && req_ready)
				predict_slot_events(req);
			if (!req_valid || req_ready) begin
				if (send_gap != 0) begin
					req_valid <= 1'b0;
					send_gap  <= send_gap - 1;
				end else if (cmd_backlog.size() != 0 &&
					!(cmd_backlog[0].hold_for_drain && slot_events_q.size() != 0)) begin
					req       <= cmd_backlog[0].item;
					req_valid <= 1'b1;
					cmd_backlog.pop_front();
					if ($urandom_range(0, 19) == 0)
						send_burst = !send_burst;
					send_gap <= send_burst ? 0 : $urandom_range(0, 6);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor with random backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready  <= 1'b0;
			sink_stall <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (slot_events_q.size() == 0) begin
					$error("unexpected result: result_kind %0d slot_index %0d last_of_run %0b",
						rsp.result_kind, rsp.slot_index, rsp.last_of_run);
					mismatches++;
				end else begin
					want = slot_events_q.pop_front();
					if (rsp.result_kind !== want.result_kind) begin
						$error("result_kind: expected %0d, actual %0d",
							want.result_kind, rsp.result_kind);
						mismatches++;
					end
					if (rsp.slot_index !== want.slot_index) begin
						$error("slot_index: expected %0d, actual %0d",
							want.slot_index, rsp.slot_index);
						mismatches++;
					end
					if (rsp.last_of_run !== want.last_of_run) begin
						$error("last_of_run: expected %0b, actual %0b",
							want.last_of_run, rsp.last_of_run);
						mismatches++;
					end
				end
				if ($urandom_range(0, 19) == 0)
					sink_burst = !sink_burst;
				hold_draw = sink_burst ? 0 : $urandom_range(0, 6);
				sink_stall <= hold_draw;
				rsp_ready  <= (hold_draw == 0);
			end else if (sink_stall != 0) begin
				sink_stall <= sink_stall - 1;
				rsp_ready  <= (sink_stall == 1);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// cycles without any transaction on either side
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	// watchdog
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	// stimulus and end of run
	initial begin
		int unsigned cur_ms;
		int          pick;
		mismatches  = 0;
		slots_taken = 0;
		send_burst  = 1'b0;
		sink_burst  = 1'b0;
		for (int i = 0; i < SLOTS; i++)
			slot_armed[i] = 1'b0;

		// ticks on an empty table, ignored fields at both extremes
		queue_cmd(ttss_pkg::OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			1'b0);
		queue_cmd(ttss_pkg::OP_TICK, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0);
		// one-shot due at zero
		queue_cmd(ttss_pkg::OP_ADD, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0);
		// due time wraps to zero, repeating with zero period
		queue_cmd(ttss_pkg::OP_ADD, 32'hFFFF_FFFF, 32'd1, 32'd0, 1'b1, 1'b0);
		// all-ones fields, period advance wraps
		queue_cmd(ttss_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			1'b0);
		queue_cmd(ttss_pkg::OP_ADD, 32'd0, 32'd10, 32'd5, 1'b1, 1'b0);
		// nonzero period but not repeating
		queue_cmd(ttss_pkg::OP_ADD, 32'd0, 32'd0, 32'd7, 1'b0, 1'b0);
		// several due at once, then nothing left due, then one by one
		queue_cmd(ttss_pkg::OP_TICK, 32'd0, $urandom, $urandom, 1'b1, 1'b0);
		queue_cmd(ttss_pkg::OP_TICK, 32'd0, $urandom, $urandom, 1'b0, 1'b0);
		queue_cmd(ttss_pkg::OP_TICK, 32'd9, $urandom, $urandom, 1'b1, 1'b0);
		queue_cmd(ttss_pkg::OP_TICK, 32'd10, $urandom, $urandom, 1'b0, 1'b0);
		queue_cmd(ttss_pkg::OP_TICK, 32'hFFFF_FFFF, $urandom, $urandom, 1'b1, 1'b0);
		queue_cmd(ttss_pkg::OP_TICK, 32'hFFFF_FFFE, $urandom, $urandom, 1'b0, 1'b0);
		// sender waits for every result before this one
		queue_cmd(ttss_pkg::OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 1'b0,
			1'b1);
		queue_cmd(ttss_pkg::OP_ADD, 32'd5, 32'h5555_5555, 32'd1, 1'b1, 1'b0);
		queue_cmd(ttss_pkg::OP_TICK, 32'h5555_5560, $urandom, $urandom, 1'b1, 1'b0);

		// random part: mostly a steady clock with periodic tasks, some noise
		cur_ms = 30;
		for (int n = 0; n < 395; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				if ($urandom_range(0, 4) != 0)
					queue_cmd(ttss_pkg::OP_ADD, cur_ms, $urandom_range(0, 30),
						$urandom_range(1, 25), 1'b1, $urandom_range(0, 49) == 0);
				else
					queue_cmd(ttss_pkg::OP_ADD, $urandom, $urandom, $urandom,
						$urandom_range(0, 1), 1'b0);
			end else if (pick < 22) begin
				queue_cmd(ttss_pkg::OP_TICK, $urandom, $urandom, $urandom,
					$urandom_range(0, 1), 1'b0);
			end else begin
				cur_ms = cur_ms + $urandom_range(0, 12);
				queue_cmd(ttss_pkg::OP_TICK, cur_ms, $urandom, $urandom,
					$urandom_range(0, 1), $urandom_range(0, 49) == 0);
			end
		end

		// reset
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// wait for all stimulus, then all results, then let the block settle
		while (cmd_backlog.size() != 0 || req_valid)
			@(posedge clk);
		while (slot_events_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && slot_events_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
